// ===== rtl/core/bva_pkg.sv =====
// Package for the bit-vector ALU core: operation codes and the mode and width field sizes.
// Used by bva_cell and bit_vector_alu_core.
`timescale 1ns / 1ps
`default_nettype none
package bva_pkg;
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_NEG  = 4'd2,
    OP_NOT  = 4'd3,
    OP_AND  = 4'd4,
    OP_EQ   = 4'd5,
    OP_ULT  = 4'd6,
    OP_SHL  = 4'd7,
    OP_SHR  = 4'd8,
    OP_MUL  = 4'd9,
    OP_UDIV = 4'd10,
    OP_UREM = 4'd11
  } op_t;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned OPW_W  = 7;
endpackage
`default_nettype wire

// ===== rtl/core/bva_cell.sv =====
// One cell of the ALU chain: one shift-add multiply step and one restoring
// divide step per enabled cycle on the token it holds. Depends on bva_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bva_cell
  import bva_pkg::*;
#(
  parameter int unsigned W   = 64,
  parameter int unsigned IDX = 0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         vld_i,
  input  wire logic [3:0]   mode_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] acc_i,
  input  wire logic [W-1:0] rem_i,
  input  wire logic [W-1:0] quo_i,
  input  wire logic [W-1:0] mask_i,
  input  wire logic [OPW_W-1:0] w_i,
  output logic              vld_o,
  output logic [3:0]        mode_o,
  output logic [W-1:0]      a_o,
  output logic [W-1:0]      b_o,
  output logic [W-1:0]      acc_o,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      mask_o,
  output logic [OPW_W-1:0]  w_o
);
  localparam int unsigned BIT = W - 1 - IDX;

  logic [W-1:0] acc_nxt, rem_nxt, quo_nxt, rs;
  logic [W:0]   trial;
  logic         vld_r;

  // Multiply step adds a shifted by IDX when bit IDX of b is set; divide step
  // brings in dividend bit BIT and subtracts the divisor when it fits.
  always_comb begin
    acc_nxt = acc_i;
    if (b_i[IDX]) begin
      acc_nxt = acc_i + (a_i << IDX);
    end
    rs      = {rem_i[W-2:0], a_i[BIT]};
    trial   = {rem_i, a_i[BIT]} - {1'b0, b_i};
    quo_nxt = quo_i;
    rem_nxt = rs;
    if (!trial[W]) begin
      rem_nxt      = trial[W-1:0];
      quo_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_o <= mode_i;
      a_o    <= a_i;
      b_o    <= b_i;
      acc_o  <= acc_nxt;
      rem_o  <= rem_nxt;
      quo_o  <= quo_nxt;
      mask_o <= mask_i;
      w_o    <= w_i;
    end
  end

  assign vld_o = vld_r;
endmodule
`default_nettype wire

// ===== rtl/core/bit_vector_alu_core.sv =====
// Top level of the bit-vector ALU: input decode, a chain of MAX_WIDTH cells
// for multiply and divide, and the result select. Depends on bva_pkg, bva_cell.
//
// Usage: an operation enters on in_valid/in_ready with in_mode, in_op_width,
// in_operand_a and in_operand_b; its result leaves on out_valid/out_ready as
// out_result. Every transaction yields exactly one result, in order.
// The path holds MAX_WIDTH + 2 register stages: one decode stage, one cell per
// operand bit (each cell runs one multiply and one divide step), and the output
// register.
// Throughput is one transaction per cycle unless the receiver stalls; the
// pipeline is a single chain whose cells all advance together.
// When the receiver stalls (out_valid high, out_ready low) the whole chain
// holds and in_ready goes low; in_ready is high exactly while the output
// register is empty or its result is being taken.
// Reset (synchronous, active low) empties every stage.
`timescale 1ns / 1ps
`default_nettype none
module bit_vector_alu_core
  import bva_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [OPW_W-1:0]     in_op_width,
  input  wire logic [63:0]          in_operand_a,
  input  wire logic [63:0]          in_operand_b,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               out_result
);
  localparam int unsigned W = MAX_WIDTH;

  logic            vld   [W+1];
  logic [3:0]      mode  [W+1];
  logic [W-1:0]    a     [W+1];
  logic [W-1:0]    b     [W+1];
  logic [W-1:0]    acc   [W+1];
  logic [W-1:0]    rem   [W+1];
  logic [W-1:0]    quo   [W+1];
  logic [W-1:0]    mask  [W+1];
  logic [OPW_W-1:0] wid  [W+1];

  logic            en;
  logic            out_valid_r;
  logic [63:0]     out_result_r;
  logic [OPW_W-1:0] w_sat;
  logic [W-1:0]    m_in;
  logic [W-1:0]    r_nxt;

  // The chain advances whenever the output register can take a new value.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Width clamp and mask.
  always_comb begin
    w_sat = in_op_width;
    if (in_op_width == '0) begin
      w_sat = OPW_W'(1);
    end else if (in_op_width > OPW_W'(W)) begin
      w_sat = OPW_W'(W);
    end
    m_in = '1;
    if (w_sat < OPW_W'(W)) begin
      m_in = ~({W{1'b1}} << w_sat);
    end
  end

  // Decode stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode[0] <= in_mode;
      a[0]    <= in_operand_a[W-1:0] & m_in;
      b[0]    <= in_operand_b[W-1:0] & m_in;
      acc[0]  <= '0;
      rem[0]  <= '0;
      quo[0]  <= '0;
      mask[0] <= m_in;
      wid[0]  <= w_sat;
    end
  end

  // Chain of cells, one per operand bit.
  for (genvar i = 0; i < W; i++) begin : g_cell
    bva_cell #(.W(W), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vld[i]), .mode_i(mode[i]), .a_i(a[i]), .b_i(b[i]),
      .acc_i(acc[i]), .rem_i(rem[i]), .quo_i(quo[i]), .mask_i(mask[i]),
      .w_i(wid[i]),
      .vld_o(vld[i+1]), .mode_o(mode[i+1]), .a_o(a[i+1]), .b_o(b[i+1]),
      .acc_o(acc[i+1]), .rem_o(rem[i+1]), .quo_o(quo[i+1]),
      .mask_o(mask[i+1]), .w_o(wid[i+1])
    );
  end

  // Result select at the end of the chain.
  always_comb begin
    r_nxt = '0;
    case (mode[W])
      OP_ADD:  r_nxt = a[W] + b[W];
      OP_SUB:  r_nxt = a[W] - b[W];
      OP_NEG:  r_nxt = '0 - a[W];
      OP_NOT:  r_nxt = ~a[W];
      OP_AND:  r_nxt = a[W] & b[W];
      OP_EQ:   r_nxt = W'(a[W] == b[W]);
      OP_ULT:  r_nxt = W'(a[W] < b[W]);
      OP_SHL:  r_nxt = (b[W] >= W'(wid[W])) ? '0 : (a[W] << b[W]);
      OP_SHR:  r_nxt = (b[W] >= W'(wid[W])) ? '0 : (a[W] >> b[W]);
      OP_MUL:  r_nxt = acc[W];
      OP_UDIV: r_nxt = (b[W] == '0) ? '1 : quo[W];
      OP_UREM: r_nxt = (b[W] == '0) ? a[W] : rem[W];
      default: r_nxt = '0;
    endcase
    r_nxt = r_nxt & mask[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= 64'(r_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");
  // The chain accepts exactly when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready mismatch");
  // A result never carries bits above its width.
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld[W] |=> (out_result[W-1:0] & ~$past(mask[W])) == '0)
    else $error("result not masked");
endmodule
`default_nettype wire
